// ===== rtl/core/dqs_pkg.sv =====
// Shared types, constants and index helpers for the deque with element statistics.
package dqs_pkg;

    // Storage geometry
    localparam int CAPACITY  = 64;
    localparam int DATA_BITS = 16;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Field widths on the stream ports
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 16;
    localparam int FIELD_CNT_W  = 7;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 32;

    // Trial-division datapath widths
    localparam int MAG_W = DATA_BITS - 1;
    localparam int DIV_W = DATA_BITS / 2 + 2;
    localparam int SQ_W  = DATA_BITS + 2;
    localparam int BIT_W = $clog2(MAG_W);

    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic signed [DATA_BITS-1:0] data_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_QUERY     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_FETCH,
        CS_PRIME,
        CS_PAL_INIT,
        CS_PAL,
        CS_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        PR_IDLE,
        PR_CHECK,
        PR_DIV
    } pr_state_t;

    typedef struct packed {
        logic  start;
        data_t value;
    } prime_req_t;

    typedef struct packed {
        logic done;
        logic prime;
    } prime_rsp_t;

    // Result item, element_count in the lowest bits
    typedef struct packed {
        status_t                status;
        logic                   is_palindrome;
        logic                   is_empty;
        logic [FIELD_CNT_W-1:0] prime_count;
        logic [FIELD_CNT_W-1:0] even_count;
        logic [FIELD_CNT_W-1:0] odd_count;
        logic [FIELD_CNT_W-1:0] element_count;
    } result_t;

    // Circular add of an offset below CAPACITY
    function automatic addr_t addr_add(addr_t a, cnt_t k);
        logic [CNT_W:0] sum;
        sum = {1'b0, CNT_W'(a)} + {1'b0, k};
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return ADDR_W'(sum);
    endfunction

    function automatic addr_t addr_inc(addr_t a);
        return (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic addr_t addr_dec(addr_t a);
        return (a == '0) ? ADDR_W'(CAPACITY - 1) : a - 1'b1;
    endfunction

endpackage

// ===== rtl/core/deque_with_element_statistics_top.sv =====
// Top level: request sequencer around the element memory and the primality unit.
// Usage:
//   Slave channel s_* carries one request item: an operation (insert front,
//   insert back, remove front, remove back, query) and a signed 16-bit value.
//   Master channel m_* returns one result item per request: element, odd, even
//   and prime counts, empty and palindrome flags, and a status (ok, removal
//   from empty, insertion into full). A failed request changes nothing.
//   One request is in work at a time; s_tready is high only while idle.
//   Steps per item: accept, then a memory read for a removal, then the prime
//   test of the inserted or removed value: decided without division for values
//   below 3 or even, else one restoring division per odd trial divisor d from
//   3 while d*d <= value, then the palindrome walk (two memory reads per
//   cycle), then the load of the output register. The divisor loop of the
//   prime unit dominates for large prime values.
//   Reset clears the queue to empty and all tallies to zero; the element
//   memory is not cleared, since only held entries are ever read.
//   The result sits in an output register; while the receiver stalls it holds,
//   and a request may be accepted meanwhile, but the next result waits for it.
module deque_with_element_statistics_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] operation, [18:3] value, [23:19] zero
    input  logic [dqs_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] element_count, [13:7] odd_count, [20:14] even_count,
    // [27:21] prime_count, [28] is_empty, [29] is_palindrome, [31:30] status
    output logic [dqs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    dqs_pkg::ctl_state_t state_reg, state_next;
    dqs_pkg::addr_t      front_reg, front_next;
    dqs_pkg::cnt_t       held_reg, held_next;
    dqs_pkg::cnt_t       odd_reg, odd_next;
    dqs_pkg::cnt_t       prm_reg, prm_next;
    logic                sub_reg, sub_next;
    dqs_pkg::status_t    status_reg, status_next;
    dqs_pkg::addr_t      lo_reg, lo_next;
    dqs_pkg::addr_t      hi_reg, hi_next;
    dqs_pkg::cnt_t       pairs_reg, pairs_next;
    logic                cmp_pend_reg, cmp_pend_next;
    logic                pal_ok_reg, pal_ok_next;
    dqs_pkg::result_t    out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                        accept;
    logic [dqs_pkg::OP_W-1:0]    in_op;
    logic signed [dqs_pkg::VALUE_W-1:0] in_val;
    dqs_pkg::data_t              in_data;
    logic                        is_ins;
    logic                        is_rem;
    logic                        full;
    logic                        empty;
    logic                        pal_issue;
    logic                        pal_mismatch;
    logic                        pal_end;
    logic                        out_free;

    logic                        wr_en;
    dqs_pkg::addr_t              wr_addr;
    dqs_pkg::data_t              wr_data;
    dqs_pkg::addr_t              rd_a_addr;
    dqs_pkg::addr_t              rd_b_addr;
    dqs_pkg::data_t              rd_a_data;
    dqs_pkg::data_t              rd_b_data;
    dqs_pkg::prime_req_t         prime_req;
    dqs_pkg::prime_rsp_t         prime_rsp;

    dqs_store u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    dqs_prime u_prime (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (prime_req),
        .rsp   (prime_rsp)
    );

    // Decode the incoming item and the walk conditions
    always_comb
    begin
        accept       = s_tvalid && s_tready;
        in_op        = s_tdata[dqs_pkg::OP_W-1:0];
        in_val       = s_tdata[dqs_pkg::OP_W + dqs_pkg::VALUE_W - 1:dqs_pkg::OP_W];
        in_data      = dqs_pkg::DATA_BITS'(in_val);
        is_ins       = (in_op == dqs_pkg::OP_INS_FRONT) || (in_op == dqs_pkg::OP_INS_BACK);
        is_rem       = (in_op == dqs_pkg::OP_REM_FRONT) || (in_op == dqs_pkg::OP_REM_BACK);
        full         = held_reg == dqs_pkg::CNT_W'(dqs_pkg::CAPACITY);
        empty        = held_reg == '0;
        pal_issue    = pairs_reg != '0;
        pal_mismatch = cmp_pend_reg && (rd_a_data != rd_b_data);
        pal_end      = pal_mismatch || (!pal_issue && !cmp_pend_reg);
        out_free     = !out_valid_reg || m_tready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dqs_pkg::CS_IDLE:
            begin
                if (accept)
                begin
                    if (is_ins && !full)
                    begin
                        state_next = dqs_pkg::CS_PRIME;
                    end
                    else if (is_rem && !empty)
                    begin
                        state_next = dqs_pkg::CS_FETCH;
                    end
                    else
                    begin
                        state_next = dqs_pkg::CS_PAL_INIT;
                    end
                end
            end
            dqs_pkg::CS_FETCH:
            begin
                state_next = dqs_pkg::CS_PRIME;
            end
            dqs_pkg::CS_PRIME:
            begin
                if (prime_rsp.done)
                begin
                    state_next = dqs_pkg::CS_PAL_INIT;
                end
            end
            dqs_pkg::CS_PAL_INIT:
            begin
                state_next = dqs_pkg::CS_PAL;
            end
            dqs_pkg::CS_PAL:
            begin
                if (pal_end)
                begin
                    state_next = dqs_pkg::CS_OUT;
                end
            end
            dqs_pkg::CS_OUT:
            begin
                if (out_free)
                begin
                    state_next = dqs_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = dqs_pkg::CS_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result register
    always_comb
    begin
        front_next      = front_reg;
        held_next       = held_reg;
        odd_next        = odd_reg;
        prm_next        = prm_reg;
        sub_next        = sub_reg;
        status_next     = status_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pairs_next      = pairs_reg;
        cmp_pend_next   = cmp_pend_reg;
        pal_ok_next     = pal_ok_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        wr_data         = in_data;
        rd_a_addr       = lo_reg;
        rd_b_addr       = hi_reg;
        prime_req.start = 1'b0;
        prime_req.value = in_data;

        unique case (state_reg)
            dqs_pkg::CS_IDLE:
            begin
                if (accept)
                begin
                    status_next = dqs_pkg::STAT_OK;
                    if (is_ins)
                    begin
                        if (full)
                        begin
                            status_next = dqs_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // Store the value and start its prime test
                            wr_en = 1'b1;
                            if (in_op == dqs_pkg::OP_INS_FRONT)
                            begin
                                wr_addr    = dqs_pkg::addr_dec(front_reg);
                                front_next = dqs_pkg::addr_dec(front_reg);
                            end
                            else
                            begin
                                wr_addr = dqs_pkg::addr_add(front_reg, held_reg);
                            end
                            held_next       = held_reg + 1'b1;
                            odd_next        = odd_reg + dqs_pkg::CNT_W'(in_data[0]);
                            sub_next        = 1'b0;
                            prime_req.start = 1'b1;
                        end
                    end
                    else if (is_rem)
                    begin
                        if (empty)
                        begin
                            status_next = dqs_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            // Fetch the leaving entry and drop it from the ends
                            if (in_op == dqs_pkg::OP_REM_FRONT)
                            begin
                                rd_a_addr  = front_reg;
                                front_next = dqs_pkg::addr_inc(front_reg);
                            end
                            else
                            begin
                                rd_a_addr = dqs_pkg::addr_add(front_reg, held_reg - 1'b1);
                            end
                            held_next = held_reg - 1'b1;
                        end
                    end
                end
            end
            dqs_pkg::CS_FETCH:
            begin
                odd_next        = odd_reg - dqs_pkg::CNT_W'(rd_a_data[0]);
                sub_next        = 1'b1;
                prime_req.start = 1'b1;
                prime_req.value = rd_a_data;
            end
            dqs_pkg::CS_PRIME:
            begin
                if (prime_rsp.done)
                begin
                    if (sub_reg)
                    begin
                        prm_next = prm_reg - dqs_pkg::CNT_W'(prime_rsp.prime);
                    end
                    else
                    begin
                        prm_next = prm_reg + dqs_pkg::CNT_W'(prime_rsp.prime);
                    end
                end
            end
            dqs_pkg::CS_PAL_INIT:
            begin
                lo_next       = front_reg;
                hi_next       = empty ? front_reg : dqs_pkg::addr_add(front_reg, held_reg - 1'b1);
                pairs_next    = held_reg >> 1;
                cmp_pend_next = 1'b0;
            end
            dqs_pkg::CS_PAL:
            begin
                // Read one pair per cycle, compare it the cycle after
                if (pal_issue)
                begin
                    lo_next    = dqs_pkg::addr_inc(lo_reg);
                    hi_next    = dqs_pkg::addr_dec(hi_reg);
                    pairs_next = pairs_reg - 1'b1;
                end
                cmp_pend_next = pal_issue;
                if (pal_end)
                begin
                    pal_ok_next = !pal_mismatch;
                end
            end
            dqs_pkg::CS_OUT:
            begin
                if (out_free)
                begin
                    out_next.element_count = dqs_pkg::FIELD_CNT_W'(held_reg);
                    out_next.odd_count     = dqs_pkg::FIELD_CNT_W'(odd_reg);
                    out_next.even_count    = dqs_pkg::FIELD_CNT_W'(held_reg - odd_reg);
                    out_next.prime_count   = dqs_pkg::FIELD_CNT_W'(prm_reg);
                    out_next.is_empty      = empty;
                    out_next.is_palindrome = pal_ok_reg;
                    out_next.status        = status_reg;
                    out_valid_next         = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqs_pkg::CS_IDLE;
            front_reg     <= '0;
            held_reg      <= '0;
            odd_reg       <= '0;
            prm_reg       <= '0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            prm_reg       <= prm_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg    <= sub_next;
        status_reg <= status_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pairs_reg  <= pairs_next;
        pal_ok_reg <= pal_ok_next;
        out_reg    <= out_next;
    end

    assign s_tready = state_reg == dqs_pkg::CS_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Tallies never exceed the number of held elements once a request is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqs_pkg::CS_IDLE) |-> ((odd_reg <= held_reg) && (prm_reg <= held_reg)))
        else $error("tally exceeds held count");

    // An insertion into a full queue leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_ins && full) |=> $stable(held_reg))
        else $error("insertion into full queue changed the count");

    // The prime unit answers only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        prime_rsp.done |-> (state_reg == dqs_pkg::CS_PRIME))
        else $error("prime result outside of prime wait");

endmodule

// ===== rtl/core/dqs_store.sv =====
// Element memory: one write port, two registered read ports.
module dqs_store (
    input  logic           clk,
    input  logic           wr_en,
    input  dqs_pkg::addr_t wr_addr,
    input  dqs_pkg::data_t wr_data,
    input  dqs_pkg::addr_t rd_a_addr,
    input  dqs_pkg::addr_t rd_b_addr,
    output dqs_pkg::data_t rd_a_data,
    output dqs_pkg::data_t rd_b_data
);

    dqs_pkg::data_t store_mem [dqs_pkg::CAPACITY];
    dqs_pkg::data_t rd_a_reg;
    dqs_pkg::data_t rd_b_reg;

    // Write the entry and register both reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= store_mem[rd_a_addr];
        rd_b_reg <= store_mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== rtl/core/dqs_prime.sv =====
// Iterative primality test by odd trial divisors, one remainder bit per cycle.
module dqs_prime (
    input  logic                clk,
    input  logic                rst_n,
    input  dqs_pkg::prime_req_t req,
    output dqs_pkg::prime_rsp_t rsp
);

    dqs_pkg::pr_state_t        state_reg, state_next;
    logic [dqs_pkg::MAG_W-1:0] n_reg, n_next;
    logic [dqs_pkg::DIV_W-1:0] d_reg, d_next;
    logic [dqs_pkg::SQ_W-1:0]  sq_reg, sq_next;
    logic [dqs_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [dqs_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic                      done_reg, done_next;
    logic                      prime_reg, prime_next;

    logic                      in_neg;
    logic [dqs_pkg::MAG_W-1:0] in_mag;
    logic                      in_small;
    logic                      in_two;
    logic                      quick;
    logic                      sq_over;
    logic [dqs_pkg::DIV_W:0]   rem_sh;
    logic [dqs_pkg::DIV_W-1:0] rem_new;

    // Classify the operand and form one restoring step
    always_comb
    begin
        in_neg   = req.value[dqs_pkg::DATA_BITS-1];
        in_mag   = req.value[dqs_pkg::MAG_W-1:0];
        in_small = in_neg || (in_mag < dqs_pkg::MAG_W'(2));
        in_two   = !in_neg && (in_mag == dqs_pkg::MAG_W'(2));
        quick    = in_small || !in_mag[0];
        sq_over  = sq_reg > dqs_pkg::SQ_W'(n_reg);
        rem_sh   = {rem_reg, n_reg[bit_reg]};
        if (rem_sh >= {1'b0, d_reg})
        begin
            rem_new = dqs_pkg::DIV_W'(rem_sh - {1'b0, d_reg});
        end
        else
        begin
            rem_new = dqs_pkg::DIV_W'(rem_sh);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dqs_pkg::PR_IDLE:
            begin
                if (req.start && !quick)
                begin
                    state_next = dqs_pkg::PR_CHECK;
                end
            end
            dqs_pkg::PR_CHECK:
            begin
                state_next = sq_over ? dqs_pkg::PR_IDLE : dqs_pkg::PR_DIV;
            end
            dqs_pkg::PR_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = (rem_new == '0) ? dqs_pkg::PR_IDLE : dqs_pkg::PR_CHECK;
                end
            end
            default:
            begin
                state_next = dqs_pkg::PR_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        unique case (state_reg)
            dqs_pkg::PR_IDLE:
            begin
                if (req.start)
                begin
                    n_next  = in_mag;
                    d_next  = dqs_pkg::DIV_W'(3);
                    sq_next = dqs_pkg::SQ_W'(9);
                    if (quick)
                    begin
                        done_next  = 1'b1;
                        prime_next = in_two;
                    end
                end
            end
            dqs_pkg::PR_CHECK:
            begin
                rem_next = '0;
                bit_next = dqs_pkg::BIT_W'(dqs_pkg::MAG_W - 1);
                if (sq_over)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                end
            end
            dqs_pkg::PR_DIV:
            begin
                rem_next = rem_new;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    if (rem_new == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        d_next  = d_reg + dqs_pkg::DIV_W'(2);
                        sq_next = sq_reg + (dqs_pkg::SQ_W'(d_reg) << 2) + dqs_pkg::SQ_W'(4);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqs_pkg::PR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        prime_reg <= prime_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.prime = prime_reg;

endmodule
